// ===== hdl/affine_vertex_transform_macros.svh =====
// assertion macros for the affine vertex transform
`ifndef AFFINE_VERTEX_TRANSFORM_MACROS_SVH
`define AFFINE_VERTEX_TRANSFORM_MACROS_SVH

`ifndef ASSERT_OFF
// checked property, quiet while reset is high
`define AVT_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// checked property, also during reset
`define AVT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define AVT_ASSERT(lbl, clk, rst, prop, msg)
`define AVT_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== hdl/avt_pkg.sv =====
// shared types and constants of the affine vertex transform
package avt_pkg;

  localparam int MAT_W      = 32;
  localparam int CFG_W      = 64;
  localparam int CFG_ADDR_W = 3;

  typedef logic [CFG_ADDR_W-1:0] reg_index_t;
  typedef logic [1:0]            mode_t;

  // register indexes
  localparam reg_index_t REG_MATRIX_LAST = 3'd5;
  localparam reg_index_t REG_MODE        = 3'd6;
  localparam reg_index_t REG_AXIS        = 3'd7;

  // transform modes
  localparam mode_t MODE_PASS  = 2'd0;
  localparam mode_t MODE_FULL  = 2'd1;
  localparam mode_t MODE_RIGID = 2'd2;

endpackage

// ===== hdl/avt_basis.sv =====
// unit basis builder: column length by integer square root, then serial division
`include "affine_vertex_transform_macros.svh"

module avt_basis #(
  parameter int FRAC_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic signed [avt_pkg::MAT_W-1:0]  mat [9],
  output logic                              basis_ready,
  output logic signed [avt_pkg::MAT_W-1:0]  unit_basis [9]
);

  localparam int MW    = avt_pkg::MAT_W;
  localparam int NUM_W = MW + FRAC_BITS + 1;
  localparam int CNT_W = $clog2(NUM_W);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SQR  = 3'd1;
  localparam logic [2:0] ST_ROOT = 3'd2;
  localparam logic [2:0] ST_NORM = 3'd3;
  localparam logic [2:0] ST_DIV  = 3'd4;

  localparam logic signed [MW-1:0] UNIT_ONE = MW'(1) << FRAC_BITS;

  logic [2:0]       state;
  logic [1:0]       col;
  logic [1:0]       idx;
  logic [CNT_W-1:0] cnt;
  logic [2*MW-1:0]  sum_sq;
  logic [2*MW-1:0]  rad;
  logic [MW+1:0]    rem_r;
  logic [MW-1:0]    root;
  logic [NUM_W-1:0] num;
  logic [MW:0]      drem;
  logic             neg;

  logic [3:0]           sel;
  logic signed [MW-1:0] v;
  logic [MW-1:0]        vmag;
  logic [2*MW-1:0]      sq;
  logic [2*MW-1:0]      sum_next;
  logic [MW+1:0]        rem_sh;
  logic [MW+1:0]        trial;
  logic [MW:0]          drem_sh;
  logic                 qbit;
  logic [NUM_W-1:0]     num_next;
  logic [MW-1:0]        q_word;

  always_comb begin
    sel      = 4'(col) * 4'd3 + 4'(idx);
    v        = mat[sel];
    vmag     = v[MW-1] ? MW'(-v) : MW'(v);
    sq       = vmag * vmag;
    sum_next = sum_sq + sq;
    rem_sh   = {rem_r[MW-1:0], rad[2*MW-1:2*MW-2]};
    trial    = {root, 2'b01};
    drem_sh  = {drem[MW-1:0], num[NUM_W-1]};
    qbit     = (drem_sh >= {1'b0, root});
    num_next = {num[NUM_W-2:0], qbit};
    q_word   = num_next[MW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst || start) begin
      state       <= ST_SQR;
      col         <= '0;
      idx         <= '0;
      sum_sq      <= '0;
      basis_ready <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
        end
        ST_SQR: begin
          if (idx == 2'd2) begin
            idx   <= '0;
            rad   <= sum_next;
            rem_r <= '0;
            root  <= '0;
            cnt   <= CNT_W'(MW - 1);
            state <= ST_ROOT;
          end else begin
            idx    <= idx + 2'd1;
            sum_sq <= sum_next;
          end
        end
        ST_ROOT: begin
          // one result bit per cycle, two radicand bits in
          if (rem_sh >= trial) begin
            rem_r <= rem_sh - trial;
            root  <= {root[MW-2:0], 1'b1};
          end else begin
            rem_r <= rem_sh;
            root  <= {root[MW-2:0], 1'b0};
          end
          rad <= rad << 2;
          if (cnt == '0) begin
            state <= ST_NORM;
          end else begin
            cnt <= cnt - CNT_W'(1);
          end
        end
        ST_NORM: begin
          if (root == '0) begin
            // zero-length column becomes the y axis
            unit_basis[sel] <= (idx == 2'd1) ? UNIT_ONE : '0;
            if (idx == 2'd2) begin
              idx <= '0;
              if (col == 2'd2) begin
                state       <= ST_IDLE;
                basis_ready <= 1'b1;
              end else begin
                col    <= col + 2'd1;
                sum_sq <= '0;
                state  <= ST_SQR;
              end
            end else begin
              idx <= idx + 2'd1;
            end
          end else begin
            num   <= (NUM_W'(vmag) << FRAC_BITS) + NUM_W'(root >> 1);
            drem  <= '0;
            neg   <= v[MW-1];
            cnt   <= CNT_W'(NUM_W - 1);
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          drem <= qbit ? (drem_sh - {1'b0, root}) : drem_sh;
          num  <= num_next;
          if (cnt == '0) begin
            unit_basis[sel] <= neg ? MW'(-q_word) : q_word;
            if (idx == 2'd2) begin
              idx <= '0;
              if (col == 2'd2) begin
                state       <= ST_IDLE;
                basis_ready <= 1'b1;
              end else begin
                col    <= col + 2'd1;
                sum_sq <= '0;
                state  <= ST_SQR;
              end
            end else begin
              idx   <= idx + 2'd1;
              state <= ST_NORM;
            end
          end else begin
            cnt <= cnt - CNT_W'(1);
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `AVT_ASSERT(a_ready_only_idle, clk, rst, basis_ready |-> state == ST_IDLE, "basis ready while busy")
  `AVT_ASSERT(a_start_drops_ready, clk, rst, start |=> !basis_ready, "stale basis after matrix write")

endmodule

// ===== hdl/affine_vertex_transform.sv =====
// top level: vertex pipeline with configuration registers and basis builder
//
//  channel | direction | transaction                | payload
//  --------+-----------+----------------------------+------------------------------
//  s_*     | in        | s_tvalid & s_tready        | s_tdata: pos_x, pos_y, pos_z
//  m_*     | out       | m_tvalid & m_tready        | m_tdata: out_x, out_y, out_z
//  cfg_*   | in        | cfg_we                     | cfg_addr, cfg_wdata
//
// one vertex per cycle through four register stages: products, partial sums with rounding,
// floor and saturation, output select with the z-up to y-up swap.
// an input vertex passes stages 1, 2 and 3 and then the output register before m_tvalid rises.
// a matrix write (and reset) restarts the unit basis build; rigid mode input waits.
// reset is synchronous and clears config and valid bits; a stall holds every full stage.
`include "affine_vertex_transform_macros.svh"

module affine_vertex_transform #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // pos_x, pos_y, pos_z from bit 0 up, zero pad to bytes
  input  logic [((3*COORD_WIDTH+7)/8)*8-1:0]  s_tdata,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // out_x, out_y, out_z from bit 0 up, zero pad to bytes
  output logic [((3*COORD_WIDTH+7)/8)*8-1:0]  m_tdata,
  input  logic                                cfg_we,
  input  logic [avt_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [avt_pkg::CFG_W-1:0]           cfg_wdata
);

  localparam int CW      = COORD_WIDTH;
  localparam int MW      = avt_pkg::MAT_W;
  localparam int TDATA_W = ((3*CW+7)/8)*8;
  localparam int PROD_W  = MW + CW;
  localparam int WIDE_W  = (CW > FRAC_BITS) ? CW : FRAC_BITS;
  localparam int ACC_W   = MW + WIDE_W + 3;
  localparam int SHR_W   = ACC_W - FRAC_BITS;

  localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (FRAC_BITS - 1);
  localparam logic signed [CW-1:0]    COORD_MIN  = {1'b1, {(CW-1){1'b0}}};
  localparam logic signed [CW-1:0]    COORD_MAX  = {1'b0, {(CW-1){1'b1}}};

  // configuration registers
  logic [avt_pkg::CFG_W-1:0] matrix_reg [6];
  avt_pkg::mode_t            mode;
  logic                      axis;
  logic                      mat_start;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) begin
        matrix_reg[i] <= '0;
      end
      mode <= avt_pkg::MODE_PASS;
      axis <= 1'b0;
    end else if (cfg_we) begin
      if (cfg_addr <= avt_pkg::REG_MATRIX_LAST) begin
        matrix_reg[cfg_addr] <= cfg_wdata;
      end else if (cfg_addr == avt_pkg::REG_MODE) begin
        mode <= cfg_wdata[1:0];
      end else begin
        axis <= cfg_wdata[0];
      end
    end
  end

  assign mat_start = cfg_we && (cfg_addr <= avt_pkg::REG_MATRIX_LAST);

  // matrix entries, column major: three basis columns then translation
  logic signed [MW-1:0] mat [12];
  logic signed [MW-1:0] mat_basis [9];
  logic signed [MW-1:0] unit_basis [9];
  logic signed [MW-1:0] coef [9];
  logic                 basis_ready;

  always_comb begin
    for (int k = 0; k < 12; k++) begin
      mat[k] = k[0] ? matrix_reg[k >> 1][2*MW-1:MW] : matrix_reg[k >> 1][MW-1:0];
    end
    for (int k = 0; k < 9; k++) begin
      mat_basis[k] = mat[k];
      coef[k]      = (mode == avt_pkg::MODE_RIGID) ? unit_basis[k] : mat[k];
    end
  end

  avt_basis #(
    .FRAC_BITS (FRAC_BITS)
  ) u_basis (
    .clk         (clk),
    .rst         (rst),
    .start       (mat_start),
    .mat         (mat_basis),
    .basis_ready (basis_ready),
    .unit_basis  (unit_basis)
  );

  // stage handshake: a stage moves when it is empty or the next one moves
  logic v1, v2, v3;
  logic adv1, adv2, adv3, adv_out;
  logic in_fire;

  assign adv_out  = !m_tvalid || m_tready;
  assign adv3     = !v3 || adv_out;
  assign adv2     = !v2 || adv3;
  assign adv1     = !v1 || adv2;
  // rigid vertices need a finished basis
  assign s_tready = adv1 && (basis_ready || (mode != avt_pkg::MODE_RIGID));
  assign in_fire  = s_tvalid && s_tready;

  // input fields
  logic signed [CW-1:0] pos [3];
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      pos[r] = s_tdata[r*CW +: CW];
    end
  end

  // stage 1: nine products, column j scales coordinate j
  logic signed [PROD_W-1:0] prod1 [9];
  logic signed [CW-1:0]     pos1 [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv1) begin
      v1 <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      for (int k = 0; k < 9; k++) begin
        prod1[k] <= coef[k] * pos[k / 3];
      end
      for (int r = 0; r < 3; r++) begin
        pos1[r] <= pos[r];
      end
    end
  end

  // stage 2: two partial sums per row, translation and rounding folded in
  logic signed [ACC_W-1:0] sa2 [3];
  logic signed [ACC_W-1:0] sb2 [3];
  logic signed [CW-1:0]    pos2 [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      for (int r = 0; r < 3; r++) begin
        sa2[r]  <= ACC_W'(prod1[r]) + ACC_W'(prod1[3+r]);
        sb2[r]  <= ACC_W'(prod1[6+r]) + (ACC_W'(mat[9+r]) <<< FRAC_BITS) + ROUND_HALF;
        pos2[r] <= pos1[r];
      end
    end
  end

  // stage 3: row sum, drop fraction (floor), saturate
  logic signed [ACC_W-1:0] row_sum [3];
  logic [SHR_W-1:0]        row_shr [3];
  logic signed [CW-1:0]    row_sat [3];
  logic signed [CW-1:0]    res3 [3];
  logic signed [CW-1:0]    pos3 [3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      row_sum[r] = sa2[r] + sb2[r];
      row_shr[r] = row_sum[r][ACC_W-1:FRAC_BITS];
      if ((&row_shr[r][SHR_W-1:CW-1]) || !(|row_shr[r][SHR_W-1:CW-1])) begin
        row_sat[r] = row_shr[r][CW-1:0];
      end else begin
        row_sat[r] = row_shr[r][SHR_W-1] ? COORD_MIN : COORD_MAX;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv3) begin
      for (int r = 0; r < 3; r++) begin
        res3[r] <= row_sat[r];
        pos3[r] <= pos2[r];
      end
    end
  end

  // output register: mode select, then optional z-up to y-up swap
  logic signed [CW-1:0] base [3];
  logic signed [CW-1:0] fin [3];
  logic signed [CW-1:0] out_q [3];
  logic                 out_valid;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      base[r] = (mode == avt_pkg::MODE_FULL || mode == avt_pkg::MODE_RIGID) ?
                res3[r] : pos3[r];
    end
    fin[0] = base[0];
    fin[1] = base[1];
    fin[2] = base[2];
    if (axis) begin
      fin[1] = base[2];
      // negating the most negative value clips to the most positive
      fin[2] = (base[1] == COORD_MIN) ? COORD_MAX : -base[1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv_out) begin
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_out) begin
      for (int r = 0; r < 3; r++) begin
        out_q[r] <= fin[r];
      end
    end
  end

  assign m_tvalid = out_valid;

  always_comb begin
    m_tdata = {TDATA_W{1'b0}};
    for (int r = 0; r < 3; r++) begin
      m_tdata[r*CW +: CW] = out_q[r];
    end
  end

  // terms for the checks below
  logic rigid_fire;
  logic pipe_full;
  logic pipe_empty;

  assign rigid_fire = in_fire && (mode == avt_pkg::MODE_RIGID);
  assign pipe_full  = m_tvalid && !m_tready && v1 && v2 && v3;
  assign pipe_empty = !m_tvalid && !v1 && !v2 && !v3;

  `AVT_ASSERT(a_rigid_needs_basis, clk, rst, rigid_fire |-> basis_ready, "rigid before basis")
  `AVT_ASSERT(a_full_pipe_stalls, clk, rst, pipe_full |-> !s_tready, "taken into full pipeline")
  `AVT_ASSERT_ALWAYS(a_reset_empties, clk, rst |=> pipe_empty, "pipeline not empty after reset")

endmodule

// ===== tb/sv/tb_affine_vertex_transform.sv =====
// testbench for the affine vertex transform: directed and random vertices against a predictor
`timescale 1ns / 100ps

module tb_affine_vertex_transform;
  import avt_pkg::*;

  localparam int          COORD_W     = 32;
  localparam int          FRAC        = 16;
  localparam int          CYCLE_LIMIT = 400000;
  // cycles after the last result before the block counts as idle
  localparam int          SETTLE      = 8;
  localparam mode_t       MODE_UNUSED = 2'd3;
  localparam logic [31:0] Q_ONE       = 32'h0001_0000;
  localparam logic [31:0] C_MAX       = 32'h7fff_ffff;
  localparam logic [31:0] C_MIN       = 32'h8000_0000;

  // one vertex as it sits on the stream: x in the lowest bits
  typedef struct packed {
    logic signed [COORD_W-1:0] z;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] x;
  } vertex_t;

  // twelve matrix entries: three basis columns, then the translation
  typedef logic [31:0] matrix_t [12];

  logic                clk;
  logic                rst;
  logic                s_tvalid;
  logic                s_tready;
  // pos_x, pos_y, pos_z from bit 0 up
  logic [3*COORD_W-1:0] s_tdata;
  logic                m_tvalid;
  logic                m_tready;
  // out_x, out_y, out_z from bit 0 up
  logic [3*COORD_W-1:0] m_tdata;
  logic                cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_W-1:0]    cfg_wdata;

  // predictor copy of the configuration and the cached unit basis
  logic [63:0]         mat_regs [6];
  mode_t               cur_mode;
  logic                cur_axis;
  logic signed [31:0]  unit_col [9];
  logic                basis_valid;

  vertex_t             expected_vertices [$];
  vertex_t             got_vertex;
  vertex_t             want_vertex;
  int                  mismatch_count;
  int                  cycle_count;
  int                  send_idle_pct;
  int                  recv_idle_pct;

  affine_vertex_transform #(
    .COORD_WIDTH(COORD_W),
    .FRAC_BITS  (FRAC)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic signed [31:0] mat_entry(int k);
    logic [63:0] r;
    r = mat_regs[k / 2];
    return (k % 2) ? r[63:32] : r[31:0];
  endfunction

  // integer square root, one result bit per step from the top
  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= n) root = trial;
    end
    return root;
  endfunction

  // normalize each basis column; a zero-length column becomes (0, 1.0, 0)
  function automatic void build_unit_basis();
    longint unsigned mags [3];
    longint unsigned sq;
    longint unsigned len;
    longint unsigned q;
    longint          e;
    for (int j = 0; j < 3; j++) begin
      sq = 0;
      for (int i = 0; i < 3; i++) begin
        e       = mat_entry(3 * j + i);
        mags[i] = (e < 0) ? -e : e;
        sq      = sq + mags[i] * mags[i];
      end
      len = int_sqrt(sq);
      for (int i = 0; i < 3; i++) begin
        if (len == 0) begin
          unit_col[3 * j + i] = (i == 1) ? Q_ONE : 32'sd0;
        end else begin
          q = ((mags[i] << FRAC) + (len >> 1)) / len;
          e = mat_entry(3 * j + i);
          unit_col[3 * j + i] = (e < 0) ? -int'(q) : int'(q);
        end
      end
    end
    basis_valid = 1'b1;
  endfunction

  function automatic logic signed [31:0] clamp32(logic signed [127:0] a);
    if (a > 128'sh7fff_ffff) return C_MAX;
    if (a < -128'sh8000_0000) return C_MIN;
    return a[31:0];
  endfunction

  // expected output vertex for one input vertex under the current settings
  function automatic vertex_t predict_vertex(vertex_t v);
    logic signed [31:0]  pin [3];
    logic signed [31:0]  coef [9];
    logic signed [31:0]  res [3];
    logic signed [127:0] acc;
    logic signed [127:0] cw;
    logic signed [127:0] pw;
    logic signed [127:0] yw;
    logic signed [31:0]  y_old;
    vertex_t             o;
    pin[0] = v.x;
    pin[1] = v.y;
    pin[2] = v.z;
    if (cur_mode == MODE_FULL || cur_mode == MODE_RIGID) begin
      if (cur_mode == MODE_RIGID && !basis_valid) build_unit_basis();
      for (int k = 0; k < 9; k++)
        coef[k] = (cur_mode == MODE_RIGID) ? unit_col[k] : mat_entry(k);
      for (int r = 0; r < 3; r++) begin
        acc = mat_entry(9 + r);
        acc = (acc <<< FRAC) + (128'sd1 <<< (FRAC - 1));
        for (int c = 0; c < 3; c++) begin
          cw  = coef[3 * c + r];
          pw  = pin[c];
          acc = acc + cw * pw;
        end
        res[r] = clamp32(acc >>> FRAC);
      end
    end else begin
      for (int r = 0; r < 3; r++) res[r] = pin[r];
    end
    // z-up to y-up: y' = z, z' = -y with saturation
    if (cur_axis) begin
      y_old  = res[1];
      yw     = y_old;
      res[1] = res[2];
      res[2] = clamp32(-yw);
    end
    o.x = res[0];
    o.y = res[1];
    o.z = res[2];
    return o;
  endfunction

  // ---------------------------------------------------------------- drivers

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatch_count++;
    $display("mismatch %s: got %h expected %h (cycle %0d)", what, got, want, cycle_count);
  endtask

  task automatic cfg_write(reg_index_t idx, logic [63:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    if (idx <= REG_MATRIX_LAST) begin
      mat_regs[idx] = val;
      basis_valid   = 1'b0;
    end else if (idx == REG_MODE) begin
      cur_mode = val[1:0];
    end else if (idx == REG_AXIS) begin
      cur_axis = val[0];
    end
  endtask

  task automatic load_matrix(matrix_t ent);
    for (int i = 0; i < 6; i++)
      cfg_write(reg_index_t'(i), {ent[2 * i + 1], ent[2 * i]});
  endtask

  task automatic set_mode(mode_t mode, logic axis);
    cfg_write(REG_MODE, 64'(mode));
    cfg_write(REG_AXIS, 64'(axis));
  endtask

  // one input transaction; the expectation is queued at the accepting edge
  task automatic send_vertex(vertex_t v);
    int gap;
    gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 4) : 0;
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= v;
    do @(posedge clk); while (!s_tready);
    expected_vertices = {expected_vertices, predict_vertex(v)};
  endtask

  // stop sending, wait for every expected result, then let the pipe settle
  task automatic drain_block();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (expected_vertices.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic vertex_t mk_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    vertex_t v;
    v.x = x;
    v.y = y;
    v.z = z;
    return v;
  endfunction

  // mostly modest magnitudes so results do not always saturate
  function automatic logic [31:0] rand_coord();
    case ($urandom_range(9))
      7, 8:    return $urandom;
      9: begin
        case ($urandom_range(4))
          0: return C_MAX;
          1: return C_MIN;
          2: return 32'hffff_ffff;
          3: return 32'd1;
          default: return 32'd0;
        endcase
      end
      default: return int'($urandom_range(0, 1 << 25)) - (1 << 24);
    endcase
  endfunction

  function automatic logic [31:0] rand_matrix_entry();
    case ($urandom_range(9))
      0: return 32'd0;
      1: return $urandom;
      2: return $urandom_range(1) ? C_MAX : C_MIN;
      default: return int'($urandom_range(0, 1 << 20)) - (1 << 19);
    endcase
  endfunction

  // random settings; some matrix writes are skipped; with none made the cached basis is reused
  task automatic configure_random();
    matrix_t ent;
    int      zc;
    for (int k = 0; k < 12; k++) ent[k] = rand_matrix_entry();
    // now and then a basis column of zero length
    if ($urandom_range(6) == 0) begin
      zc = $urandom_range(2);
      for (int i = 0; i < 3; i++) ent[3 * zc + i] = 32'd0;
    end
    set_mode(mode_t'($urandom_range(3)), 1'($urandom_range(1)));
    for (int i = 0; i < 6; i++) begin
      if ($urandom_range(1))
        cfg_write(reg_index_t'(i), {ent[2 * i + 1], ent[2 * i]});
    end
  endtask

  // ---------------------------------------------------------------- tests

  // mode and axis from reset: vertices come back unchanged
  task automatic test_pass_through();
    send_vertex(mk_vertex(32'd0, 32'd0, 32'd0));
    send_vertex(mk_vertex(C_MAX, C_MIN, 32'hffff_ffff));
    send_vertex(mk_vertex(C_MIN, C_MAX, 32'd1));
    send_vertex(mk_vertex(32'h5555_5555, 32'haaaa_aaaa, 32'h0f0f_f0f0));
    drain_block();
  endtask

  // rigid mode on the reset matrix: every column has zero length
  task automatic test_rigid_after_reset();
    set_mode(MODE_RIGID, 1'b0);
    send_vertex(mk_vertex(Q_ONE, 32'h0002_0000, 32'hfffd_0000));
    drain_block();
  endtask

  task automatic test_full_bake();
    matrix_t m;
    set_mode(MODE_FULL, 1'b0);
    // identity with translation (1.5, -2.0, 0.5)
    m = '{Q_ONE, 0, 0, 0, Q_ONE, 0, 0, 0, Q_ONE,
          32'h0001_8000, 32'hfffe_0000, 32'h0000_8000};
    load_matrix(m);
    send_vertex(mk_vertex(Q_ONE, 32'h0002_0000, 32'h0003_0000));
    send_vertex(mk_vertex(32'hffff_8000, 32'h0000_7fff, 32'hffff_ffff));
    drain_block();
    // scale by one half: exact halves round toward plus infinity
    m = '{32'h8000, 0, 0, 0, 32'h8000, 0, 0, 0, 32'h8000, 0, 0, 0};
    load_matrix(m);
    send_vertex(mk_vertex(32'd1, 32'hffff_ffff, 32'd3));
    send_vertex(mk_vertex(32'hffff_fffd, 32'd5, 32'hffff_fffb));
    drain_block();
    // largest entries everywhere: sums run past both ends of the range
    m = '{C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX,
          C_MAX, C_MAX, C_MAX};
    load_matrix(m);
    send_vertex(mk_vertex(C_MAX, C_MAX, C_MAX));
    send_vertex(mk_vertex(C_MIN, C_MIN, C_MIN));
    drain_block();
  endtask

  // one regular column, one zero column, one column holding the most negative entry
  task automatic test_rigid_bake();
    matrix_t m;
    m = '{32'h0003_0000, 32'h0004_0000, 0, 0, 0, 0, C_MIN, 0, C_MAX,
          32'h0000_4000, 32'hffff_c000, 32'h0007_0000};
    load_matrix(m);
    set_mode(MODE_RIGID, 1'b0);
    send_vertex(mk_vertex(Q_ONE, Q_ONE, Q_ONE));
    send_vertex(mk_vertex(C_MAX, C_MIN, 32'h1234_5678));
    drain_block();
  endtask

  // y' = z and z' = -y, including negation of the most negative value
  task automatic test_axis_convert();
    set_mode(MODE_PASS, 1'b1);
    send_vertex(mk_vertex(32'd5, C_MIN, 32'd7));
    send_vertex(mk_vertex(32'd0, C_MAX, 32'hffff_ffff));
    drain_block();
    set_mode(MODE_FULL, 1'b1);
    send_vertex(mk_vertex(32'h0002_0000, 32'hffff_0000, 32'h0000_8000));
    drain_block();
  endtask

  // the spare mode code behaves as pass through
  task automatic test_unused_mode();
    set_mode(MODE_UNUSED, 1'b0);
    send_vertex(mk_vertex(32'hdead_beef, 32'h0123_4567, C_MIN));
    send_vertex(mk_vertex(C_MAX, 32'd0, 32'h8000_0001));
    drain_block();
  endtask

  // random settings, each followed by a burst of random vertices
  task automatic test_random_traffic(int s_pct, int r_pct, int n_items);
    int sent;
    int burst;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    sent          = 0;
    while (sent < n_items) begin
      configure_random();
      burst = $urandom_range(20, 80);
      for (int i = 0; i < burst; i++)
        send_vertex(mk_vertex(rand_coord(), rand_coord(), rand_coord()));
      sent += burst;
      drain_block();
    end
  endtask

  // ---------------------------------------------------------------- checking

  // output transactions are compared against the oldest expectation
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got_vertex = m_tdata;
      if (expected_vertices.size() == 0) begin
        report_mismatch("unexpected vertex", got_vertex.x, 32'd0);
      end else begin
        want_vertex = expected_vertices.pop_front();
        if (got_vertex.x !== want_vertex.x) report_mismatch("out_x", got_vertex.x, want_vertex.x);
        if (got_vertex.y !== want_vertex.y) report_mismatch("out_y", got_vertex.y, want_vertex.y);
        if (got_vertex.z !== want_vertex.z) report_mismatch("out_z", got_vertex.z, want_vertex.z);
      end
    end
  end

  // receiver back pressure, redrawn every cycle
  always @(negedge clk) begin
    m_tready <= rst ? 1'b0 : ($urandom_range(99) >= recv_idle_pct);
  end

  // hard stop in case a transaction never completes
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    rst            = 1'b1;
    s_tvalid       = 1'b0;
    s_tdata        = '0;
    m_tready       = 1'b0;
    cfg_we         = 1'b0;
    cfg_addr       = '0;
    cfg_wdata      = '0;
    mismatch_count = 0;
    cycle_count    = 0;
    send_idle_pct  = 0;
    recv_idle_pct  = 0;
    cur_mode       = MODE_PASS;
    cur_axis       = 1'b0;
    basis_valid    = 1'b0;
    for (int i = 0; i < 6; i++) mat_regs[i] = '0;
    for (int i = 0; i < 9; i++) unit_col[i] = '0;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_pass_through();
    test_rigid_after_reset();
    test_full_bake();
    test_rigid_bake();
    test_axis_convert();
    test_unused_mode();
    test_random_traffic(20, 48, 430);
    test_random_traffic(48, 20, 430);
    test_random_traffic(0, 0, 430);

    drain_block();
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/avt_pkg.sv
hdl/avt_basis.sv
hdl/affine_vertex_transform.sv
tb/sv/tb_affine_vertex_transform.sv
